// ===== hw/rtl/hsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsr_pkg: shared types and constants for the hash shard router
// FNV-1a constants, beat codes, the job record passed from front to back,
// and the back-end state type.
// ---------------------------------------------------------------------------
package hsr_pkg;

  // FNV-1a 32-bit
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // namespace length limit (counter saturates here)
  localparam logic [5:0] NAME_LIMIT = 6'd63;

  // shard count register
  localparam logic [6:0] SHARD_COUNT_RESET = 7'd8;
  localparam int         MAX_SHARDS_DEF    = 64;

  // beat function codes
  localparam logic [1:0] FUNC_NAME = 2'd0;
  localparam logic [1:0] FUNC_KEY  = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  // front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;

  // modulo unit: dividend bits retired per cycle
  localparam int MOD_BITS_PER_STEP = 4;
  localparam int MOD_STEPS         = 32 / MOD_BITS_PER_STEP;

  // one finished request waiting for its modulo
  typedef struct packed {
    logic [31:0] hash;
    logic        bad;
  } hsr_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // one FNV-1a round
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return 32'(x * FNV_PRIME);
  endfunction

  // legal namespace character; digits not in first position
  function automatic logic char_allowed(input logic [7:0] c, input logic first);
    logic ok;
    ok = (c == 8'h5F) ||
         (c >= 8'h61 && c <= 8'h7A) ||
         (c >= 8'h41 && c <= 8'h5A) ||
         (!first && c >= 8'h30 && c <= 8'h39);
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hsr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsr_in_if: request beat channel
// Valid/ready channel carrying one namespace, key or end beat.
// ---------------------------------------------------------------------------
interface hsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hsr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsr_out_if: routing result channel
// Valid/ready channel carrying shard index, status and full hash.
// ---------------------------------------------------------------------------
interface hsr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  shard_index;
  logic        status;
  logic [31:0] hash_value;

  modport source (output valid, output shard_index, output status, output hash_value,
                  input ready);
  modport sink   (input valid, input shard_index, input status, input hash_value,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hsr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsr_queue: job queue between front and back
// Small FIFO of finished hashes; lets the front keep taking beats while
// the modulo unit works.
// ---------------------------------------------------------------------------
module hsr_queue
  import hsr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire hsr_job_t wdata,
  output logic          full,
  output logic          rd_valid,
  input  wire logic     pop,
  output hsr_job_t      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hsr_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rdata    = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hsr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsr_front: beat intake, namespace check and FNV-1a hashing
// One FNV round per cycle. The first key beat of a request also needs the
// zero separator round, so it holds the byte and stalls until its round.
// ---------------------------------------------------------------------------
module hsr_front
  import hsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  hsr_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      q_push,
  output hsr_job_t  q_wdata
);

  logic [31:0] hash_r,  hash_nxt;
  logic [5:0]  len_r,   len_nxt;
  logic        bad_r,   bad_nxt;
  logic        sep_r,   sep_nxt;
  logic        pend_r,  pend_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;

  logic        accept;
  logic        is_key, is_end;
  logic [7:0]  mix_b;
  logic [31:0] mix_out;

  assign in_ch.ready = !pend_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_key      = (in_ch.func == FUNC_KEY);
  assign is_end      = (in_ch.func == FUNC_END);

  // single FNV round, operand byte selected per case
  always_comb begin
    if (pend_r) begin
      mix_b = pbyte_r;
    end else if ((is_key && !sep_r) || is_end) begin
      mix_b = 8'd0;
    end else begin
      mix_b = in_ch.data_byte;
    end
  end
  assign mix_out = fnv_mix(hash_r, mix_b);

  // finished request into the queue
  assign q_push       = accept && is_end;
  assign q_wdata.hash = sep_r ? hash_r : mix_out;
  assign q_wdata.bad  = bad_r || (len_r == '0);

  // request state update
  always_comb begin
    hash_nxt  = hash_r;
    len_nxt   = len_r;
    bad_nxt   = bad_r;
    sep_nxt   = sep_r;
    pend_nxt  = pend_r;
    pbyte_nxt = pbyte_r;
    if (pend_r) begin
      // held key byte after the separator round
      hash_nxt = mix_out;
      pend_nxt = 1'b0;
    end else if (accept) begin
      unique case (in_ch.func)
        FUNC_NAME: begin
          if (sep_r || (len_r >= NAME_LIMIT) ||
              !char_allowed(in_ch.data_byte, len_r == '0)) begin
            bad_nxt = 1'b1;
          end
          if (len_r < NAME_LIMIT) begin
            len_nxt = len_r + 1'b1;
          end
          hash_nxt = mix_out;
        end
        FUNC_KEY: begin
          hash_nxt = mix_out;
          if (!sep_r) begin
            sep_nxt   = 1'b1;
            pend_nxt  = 1'b1;
            pbyte_nxt = in_ch.data_byte;
          end
        end
        FUNC_END: begin
          hash_nxt = FNV_BASIS;
          len_nxt  = '0;
          bad_nxt  = 1'b0;
          sep_nxt  = 1'b0;
        end
        default: begin
          // unused code: beat dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      len_r  <= '0;
      bad_r  <= 1'b0;
      sep_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
      bad_r  <= bad_nxt;
      sep_r  <= sep_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pbyte_r <= pbyte_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hsr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hsr_back: shard index computation and result register
// Restoring modulo of the 32-bit hash by the shard count, a few dividend
// bits per cycle, then the result beat is held in the output register.
// ---------------------------------------------------------------------------
module hsr_back
  import hsr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [6:0] shard_count,
  input  wire logic       q_valid,
  input  wire hsr_job_t   q_rdata,
  output logic            q_pop,
  hsr_out_if.source       out_ch
);

  localparam int SW = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  back_state_t   state_r, state_nxt;
  logic [31:0]   div_r;
  logic [5:0]    rem_r;
  logic [SW-1:0] cnt_r;
  hsr_job_t      job_r;
  logic          load_out;
  logic [31:0]   div_step;
  logic [5:0]    rem_step;

  logic          ovalid_r;
  logic [5:0]    oidx_r;
  logic          ostat_r;
  logic [31:0]   ohash_r;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.shard_index = oidx_r;
  assign out_ch.status      = ostat_r;
  assign out_ch.hash_value  = ohash_r;

  // one modulo step: MOD_BITS_PER_STEP restoring rounds
  always_comb begin
    logic [6:0] trial;
    div_step = div_r;
    rem_step = rem_r;
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      trial    = {rem_step, div_step[31]};
      div_step = {div_step[30:0], 1'b0};
      if (trial >= shard_count) begin
        trial = trial - shard_count;
      end
      rem_step = trial[5:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == SW'(MOD_STEPS - 1)) state_nxt = BK_DONE;
      BK_DONE: if (!ovalid_r || out_ch.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop    = q_valid;
      BK_DIV:  ;
      BK_DONE: load_out = !ovalid_r || out_ch.ready;
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      if (q_pop) begin
        cnt_r <= '0;
      end else if (state_r == BK_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_rdata;
      div_r <= q_rdata.hash;
      rem_r <= '0;
    end else if (state_r == BK_DIV) begin
      div_r <= div_step;
      rem_r <= rem_step;
    end
    if (load_out) begin
      oidx_r  <= job_r.bad ? 6'd0 : rem_r;
      ostat_r <= job_r.bad;
      ohash_r <= job_r.hash;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hash_shard_router.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hash_shard_router: FNV-1a request hashing and shard selection
// Top level tying the beat front end, job queue and modulo back end.
// ---------------------------------------------------------------------------
// A request is a run of beats: namespace bytes, key bytes, then an end beat.
// The front end takes one beat per cycle while the queue has room and no
// key byte is held, and runs FNV-1a over namespace, a zero separator and
// key; the first key beat holds its byte and drops ready for the byte
// round, since that round and the separator round share the one FNV
// multiplier. Each end beat drops the finished hash into a two-entry queue,
// and the back end reduces it modulo shard_count at four bits a cycle, one
// job at a time, taking the next once the result is in its output register.
// A result waiting on out_ch does not stop the front end taking beats until
// the queue is full. Writes to cfg_wdata outside 1..MAX_SHARDS are ignored.
// ---------------------------------------------------------------------------
module hash_shard_router
  import hsr_pkg::*;
#(
  parameter int MAX_SHARDS = MAX_SHARDS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  hsr_in_if.sink          in_ch,
  hsr_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);

  logic [6:0] shard_count_r;
  logic       q_push, q_full, q_valid, q_pop;
  hsr_job_t   q_wdata, q_rdata;

  // shard count register, out-of-range writes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shard_count_r <= SHARD_COUNT_RESET;
    end else if (cfg_we && (cfg_wdata != 7'd0) && (cfg_wdata <= 7'(MAX_SHARDS))) begin
      shard_count_r <= cfg_wdata;
    end
  end

  hsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  hsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rdata    (q_rdata)
  );

  hsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .shard_count (shard_count_r),
    .q_valid     (q_valid),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // invalid namespace always routes to shard zero
  a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |-> (out_ch.shard_index == 6'd0))
    else $error("invalid namespace with nonzero shard index");

  // valid result is below the shard count
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.status) |-> ({1'b0, out_ch.shard_index} < shard_count_r))
    else $error("shard index out of range");

  // pop only with data present
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== tb/hash_shard_router_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hash_shard_router_tb: self-checking bench for the hash shard router
// Streams namespace/key/end beats through the request channel, predicts the
// FNV-1a hash, namespace status and shard index of every request, and checks
// each result beat in order. Runs a short directed table, then phases of
// random requests under different shard counts, with bursty sending, a
// patterned result stall and one long output hold-off.
// ---------------------------------------------------------------------------
module hash_shard_router_tb;
  import hsr_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 10;
  // Worst case is roughly one result per beat, each waiting out the back end
  // and a slow receiver window; several times that keeps clear of real runs.
  localparam int CYCLE_LIMIT = 600000;
  // room for the back end to finish its job and the two queued behind it
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 500;
  localparam int N_PHASES = 12;
  localparam int PHASE_BEATS = 140;
  localparam int DIR_ROWS = 24;
  localparam int MAX_PRINTS = 40;

  // beat code the block ignores
  localparam logic [1:0] FUNC_NOP = 2'd3;

  // result status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  // hash of a request with nothing but the separator in it
  localparam logic [31:0] EMPTY_HASH = 32'h050C5D1F;

  typedef struct packed {
    logic [5:0]  shard;
    logic        status;
    logic [31:0] hash;
  } route_t;

  // how a directed row's result is known
  typedef enum logic [1:0] {
    EXP_MODEL,   // from the predictor
    EXP_REJECT,  // shard 0, status bad, hash from predictor
    EXP_EMPTY    // fully typed: empty request
  } exp_tag_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    exp_tag_e   tag;
  } dir_row_t;

  // request shapes for the random part
  typedef enum logic [2:0] {
    FL_NONE,
    FL_BAD_CHAR,
    FL_DIGIT_FIRST,
    FL_NAME_AFTER_KEY
  } flaw_e;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  hsr_in_if  in_ch ();
  hsr_out_if out_ch ();

  hash_shard_router DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  logic [31:0] run_hash  = FNV_BASIS;
  logic [5:0]  name_len  = 6'd0;
  logic        name_err  = 1'b0;
  logic        sep_done  = 1'b0;
  logic [6:0]  shard_cnt = SHARD_COUNT_RESET;

  route_t      pending_routes[$];
  int unsigned err_cnt = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned cycle_cnt = 0;

  dir_row_t    dir_tab[DIR_ROWS];
  logic [6:0]  phase_cfg[N_PHASES];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [31:0] hash_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h0, b};
    return x * FNV_PRIME;
  endfunction

  function automatic logic name_char_ok(input logic [7:0] c, input logic lead);
    if (c == "_") return 1'b1;
    if (c >= "a" && c <= "z") return 1'b1;
    if (c >= "A" && c <= "Z") return 1'b1;
    return !lead && c >= "0" && c <= "9";
  endfunction

  // advance the predicted request state by one accepted beat
  task automatic route_step(input logic [1:0] f, input logic [7:0] d);
    route_t      r;
    logic [31:0] h;
    logic [31:0] m;
    case (f)
      FUNC_NAME: begin
        if (sep_done) name_err = 1'b1;
        if (name_len == NAME_LIMIT) name_err = 1'b1;
        else if (!name_char_ok(d, name_len == 6'd0)) name_err = 1'b1;
        if (name_len != NAME_LIMIT) name_len++;
        run_hash = hash_round(run_hash, d);
      end
      FUNC_KEY: begin
        if (!sep_done) begin
          run_hash = hash_round(run_hash, 8'h00);
          sep_done = 1'b1;
        end
        run_hash = hash_round(run_hash, d);
      end
      FUNC_END: begin
        h = sep_done ? run_hash : hash_round(run_hash, 8'h00);
        m = h % {25'd0, shard_cnt};
        r.hash   = h;
        r.status = (name_err || name_len == 6'd0) ? ST_BAD : ST_OK;
        r.shard  = (r.status == ST_BAD) ? 6'd0 : m[5:0];
        pending_routes.push_back(r);
        run_hash = FNV_BASIS;
        name_len = 6'd0;
        name_err = 1'b0;
        sep_done = 1'b0;
      end
      default: ;
    endcase
  endtask

  // offer one beat in bursts with random gaps, predict once it is taken
  task automatic send_beat(input logic [1:0] f, input logic [7:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.data_byte <= d;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (f != FUNC_NOP) beats_sent++;
    route_step(f, d);
  endtask

  // stop sending, let every result come back and the pipe go quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    // out-of-range writes leave the register alone
    if (v >= 7'd1 && v <= 7'(MAX_SHARDS_DEF)) shard_cnt = v;
  endtask

  function automatic logic [7:0] rand_name_char(input logic lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_bad_char(input logic lead);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (name_char_ok(c, lead));
    return c;
  endfunction

  // one request: namespace, key, end, with an optional defect
  task automatic send_request(input int nlen, input int klen, input flaw_e flaw);
    int         i;
    int         bad_pos;
    logic [7:0] c;
    bad_pos = (nlen > 0) ? $urandom_range(0, nlen - 1) : 0;
    for (i = 0; i < nlen; i++) begin
      c = rand_name_char(i == 0);
      if (flaw == FL_BAD_CHAR && i == bad_pos) c = rand_bad_char(i == 0);
      if (flaw == FL_DIGIT_FIRST && i == 0) c = 8'("0" + $urandom_range(0, 9));
      send_beat(FUNC_NAME, c);
      if ($urandom_range(0, 40) == 0) send_beat(FUNC_NOP, 8'($urandom));
    end
    for (i = 0; i < klen; i++) begin
      c = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_beat(FUNC_KEY, c);
    end
    if (flaw == FL_NAME_AFTER_KEY) send_beat(FUNC_NAME, rand_name_char(1'b0));
    send_beat(FUNC_END, 8'($urandom));
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70)
      send_request(($urandom_range(0, 19) == 0) ? $urandom_range(13, 63)
                                                : $urandom_range(1, 12),
                   $urandom_range(0, 10), FL_NONE);
    else if (r < 78)
      send_request($urandom_range(1, 12), $urandom_range(0, 8), FL_BAD_CHAR);
    else if (r < 83)
      send_request($urandom_range(1, 8), $urandom_range(0, 8), FL_DIGIT_FIRST);
    else if (r < 88)
      send_request($urandom_range(1, 8), $urandom_range(1, 6), FL_NAME_AFTER_KEY);
    else if (r < 92)
      send_request(0, $urandom_range(0, 4), FL_NONE);
    else if (r < 96)
      send_request($urandom_range(64, 80), $urandom_range(0, 4), FL_NONE);
    else
      send_request(63, $urandom_range(0, 4), FL_NONE);
  endtask

  // result side: check each beat, then stall on its own pattern
  initial begin
    route_t      want;
    int unsigned pct;
    int unsigned win_left;
    int unsigned hold_left;
    int unsigned hold_ack_cnt;
    pct          = 100;
    win_left     = 0;
    hold_left    = 0;
    hold_ack_cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_routes.size() == 0) begin
          report_mismatch("result beat with none pending, hash", out_ch.hash_value, 32'h0);
        end else begin
          want = pending_routes.pop_front();
          if (out_ch.shard_index !== want.shard)
            report_mismatch("shard_index", 32'(out_ch.shard_index), 32'(want.shard));
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.hash_value !== want.hash)
            report_mismatch("hash_value", out_ch.hash_value, want.hash);
        end
      end
      if (hold_ack_cnt != hold_req_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (win_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1: pct = 100;
            2: pct = 70;
            3: pct = 40;
            default: pct = 10;
          endcase
          win_left = $urandom_range(16, 96);
        end
        win_left--;
        out_ch.ready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int ph;
    int i;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_NAME;
    in_ch.data_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_wdata       = 7'd0;
    rst_n           = 1'b0;

    dir_tab = '{
      '{FUNC_END,  8'h00, EXP_EMPTY},   // empty request straight after reset
      '{FUNC_NOP,  8'hFF, EXP_MODEL},   // ignored beat
      '{FUNC_NAME, "a",   EXP_MODEL},
      '{FUNC_NAME, "Z",   EXP_MODEL},
      '{FUNC_NAME, "_",   EXP_MODEL},
      '{FUNC_NAME, "9",   EXP_MODEL},   // digit past the first position
      '{FUNC_KEY,  8'h00, EXP_MODEL},   // zero key byte is plain data
      '{FUNC_KEY,  8'hFF, EXP_MODEL},
      '{FUNC_END,  8'hFF, EXP_MODEL},
      '{FUNC_NAME, "0",   EXP_MODEL},   // digit leading the namespace
      '{FUNC_END,  8'h01, EXP_REJECT},
      '{FUNC_NAME, 8'h00, EXP_MODEL},   // zero byte in the namespace
      '{FUNC_KEY,  "k",   EXP_MODEL},
      '{FUNC_END,  8'h00, EXP_REJECT},
      '{FUNC_NAME, "n",   EXP_MODEL},
      '{FUNC_KEY,  "x",   EXP_MODEL},
      '{FUNC_NAME, "y",   EXP_MODEL},   // namespace beat after a key beat
      '{FUNC_END,  8'h00, EXP_REJECT},
      '{FUNC_KEY,  8'h01, EXP_MODEL},   // key with no namespace
      '{FUNC_END,  8'h00, EXP_REJECT},
      '{FUNC_NAME, "z",   EXP_MODEL},   // empty key, separator at the end
      '{FUNC_END,  8'h00, EXP_MODEL},
      '{FUNC_NAME, 8'h7B, EXP_MODEL},   // just past 'z'
      '{FUNC_END,  8'h00, EXP_REJECT}
    };
    // covers both range ends, ignored values and every data bit
    phase_cfg = '{7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd63, 7'd65, 7'd7,
                  7'd33, 7'd2, 7'd48, 7'd64};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, shard count at its reset value
    for (i = 0; i < DIR_ROWS; i++) begin
      send_beat(dir_tab[i].func, dir_tab[i].data);
      if (dir_tab[i].tag != EXP_MODEL) begin
        pending_routes[pending_routes.size() - 1].shard  = 6'd0;
        pending_routes[pending_routes.size() - 1].status = ST_BAD;
        if (dir_tab[i].tag == EXP_EMPTY)
          pending_routes[pending_routes.size() - 1].hash = EMPTY_HASH;
      end
    end
    drain();

    // random phases, each under its own shard count
    for (ph = 0; ph < N_PHASES; ph++) begin
      cfg_write(phase_cfg[ph]);
      beats_sent = 0;
      if (ph == 0) begin
        // namespace length limit: longest legal, then one over
        send_request(63, 2, FL_NONE);
        send_request(64, 2, FL_NONE);
      end
      // output held off while requests keep coming, so the input backs up
      if (ph == 2) hold_req_cnt++;
      while (beats_sent < PHASE_BEATS) random_request();
      drain();
    end

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
